// ----- hw/rtl/bba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam int PAGE_SHIFT = 12;
	localparam logic [12:0] PAGE_SIZE = 13'h1000;
	localparam logic [11:0] PAGE_MASK = 12'hFFF;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_FULL   = 2'd2,
		ST_SMALL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_BMP,
		OP_TRIM,
		OP_ALIGN,
		OP_MAP,
		OP_LAY,
		OP_SEARCH,
		OP_TAKE,
		OP_SPLIT,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t st;
	} cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic full;
		logic oob;
		logic small_rgn;
		logic hit;
		logic top;
		logic lay_last;
		logic split_done;
	} flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/buddy_block_allocator_top.sv -----
// Add: bitmap, trim, align and map-check steps, then one layout step per order through
//   the single write port of the slot RAM; a full table or too-small region ends early.
// Allocate: orders are scanned upward from the request, then the block is halved down;
//   one word at a time. No free block or a bad order gives NOFREE status.
// Reset clears the region count, the free-block valid bits, the map base offset and the
//   handshakes; the slot address RAM needs no clearing pass, words are taken right away.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator_top
	import bba_pkg::*;
#(
	parameter int MAX_REGIONS = 8,
	parameter int NUM_ORDERS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// configuration port, one 64-bit register at byte address 0
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,

	// request word
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [47:0] region_base,
	input  wire logic [47:0] region_len,
	input  wire logic [4:0]  block_order,

	// result word
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  status,
	output logic      [63:0] block_address,
	output logic      [2:0]  region_index
);

	logic [63:0] map_base_q;
	logic        reg_hit;
	cmd_t        cmd;
	flags_t      flags;

	// registers sit at 8-byte strides; only slot zero exists
	assign reg_hit = (paddr[3] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? map_base_q : 64'd0;

	// latch the map base offset on the access phase of a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_base_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			map_base_q <= pwdata;
		end
	end

	// sequencer: accepts one word at a time and steps the datapath
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// datapath: region count, free-block valid bits, slot address RAM, result register
	bba_datapath #(
		.MAX_REGIONS (MAX_REGIONS),
		.NUM_ORDERS  (NUM_ORDERS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.flags         (flags),
		.map_base      (map_base_q),
		.req_type      (req_type),
		.region_base   (region_base),
		.region_len    (region_len),
		.block_order   (block_order),
		.status        (status),
		.block_address (block_address),
		.region_index  (region_index)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/bba_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl
	import bba_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  wire logic   out_ready,
	input  wire flags_t flags,
	output cmd_t        cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_BMP,
		S_TRIM,
		S_ALIGN,
		S_MAPCHK,
		S_LAY,
		S_SEARCH,
		S_TAKE,
		S_SPLIT,
		S_EMIT
	} state_t;

	state_t  state_q;
	status_t st_q;
	logic    out_valid_q;
	logic    emit_go;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.op = OP_NONE;
		cmd.st = st_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) cmd.op = OP_LOAD;
			S_DISPATCH: cmd.op = OP_NONE;
			S_BMP:      cmd.op = OP_BMP;
			S_TRIM:     cmd.op = OP_TRIM;
			S_ALIGN:    cmd.op = OP_ALIGN;
			S_MAPCHK:   cmd.op = OP_MAP;
			S_LAY:      cmd.op = OP_LAY;
			S_SEARCH:   cmd.op = OP_SEARCH;
			S_TAKE:     cmd.op = OP_TAKE;
			S_SPLIT:    if (!flags.split_done) cmd.op = OP_SPLIT;
			S_EMIT:     if (emit_go) cmd.op = OP_EMIT;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// the output word drains independently of the sequencer
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (flags.is_alloc) begin
						if (flags.oob) begin
							st_q    <= ST_NOFREE;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SEARCH;
						end
					end else if (flags.full) begin
						st_q    <= ST_FULL;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_BMP;
					end
				end
				S_BMP:   state_q <= S_TRIM;
				S_TRIM:  state_q <= S_ALIGN;
				S_ALIGN: state_q <= S_MAPCHK;
				S_MAPCHK: begin
					if (flags.small_rgn) begin
						st_q    <= ST_SMALL;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_LAY;
					end
				end
				S_LAY: begin
					if (flags.lay_last) begin
						st_q    <= ST_OK;
						state_q <= S_EMIT;
					end
				end
				S_SEARCH: begin
					if (flags.hit) begin
						state_q <= S_TAKE;
					end else if (flags.top) begin
						st_q    <= ST_NOFREE;
						state_q <= S_EMIT;
					end
				end
				S_TAKE: state_q <= S_SPLIT;
				S_SPLIT: begin
					if (flags.split_done) begin
						st_q    <= ST_OK;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bba_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bba_datapath
	import bba_pkg::*;
#(
	parameter int MAX_REGIONS = 8,
	parameter int NUM_ORDERS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output flags_t           flags,
	input  wire logic [63:0] map_base,
	input  wire logic        req_type,
	input  wire logic [47:0] region_base,
	input  wire logic [47:0] region_len,
	input  wire logic [4:0]  block_order,
	output logic      [1:0]  status,
	output logic      [63:0] block_address,
	output logic      [2:0]  region_index
);

	localparam int RW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int OW    = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int RCW   = $clog2(MAX_REGIONS + 1);
	localparam int SW    = RW + OW;
	localparam int DEPTH = 1 << SW;

	// control state
	logic [RCW-1:0]                         rc_q;
	logic [MAX_REGIONS-1:0][NUM_ORDERS-1:0] valid_q;

	// working registers
	logic          is_alloc_q;
	logic          oob_q;
	logic          small_q;
	logic [49:0]   base_q;
	logic [47:0]   len_q;
	logic [35:0]   bmp_q;
	logic [63:0]   next_q;
	logic [47:0]   size_q;
	logic [OW-1:0] o_q;
	logic [OW-1:0] order_q;
	logic [RW-1:0] r_q;
	logic [63:0]   addr_q;

	logic [48:0]           len_up;
	logic [38:0]           dbl;
	logic [12:0]           pad;
	logic [MAX_REGIONS-1:0] col;
	logic [RW-1:0]         pick;
	logic [RW-1:0]         rc_idx;
	logic [OW-1:0]         o_dn;

	logic          ram_we;
	logic [SW-1:0] ram_waddr;
	logic [63:0]   ram_wdata;
	logic          ram_re;
	logic [SW-1:0] ram_raddr;
	logic [63:0]   ram_rdata;

	assign rc_idx = rc_q[RW-1:0];
	assign o_dn   = o_q - OW'(1);

	// bitmap bytes: ceil(2 * ceil(len / page) / 8)
	assign len_up = {1'b0, len_q} + 49'(PAGE_MASK);
	assign dbl    = {1'b0, len_up[48:PAGE_SHIFT], 1'b0} + 39'd7;

	assign pad = (base_q[11:0] != 12'd0) ? (PAGE_SIZE - {1'b0, base_q[11:0]}) : 13'd0;

	// lowest region holding a free block at the current order
	always_comb begin
		pick = '0;
		for (int r = 0; r < MAX_REGIONS; r++) begin
			col[r] = valid_q[r][o_q];
		end
		for (int r = MAX_REGIONS - 1; r >= 0; r--) begin
			if (col[r]) pick = RW'(r);
		end
	end

	always_comb begin
		flags.is_alloc   = is_alloc_q;
		flags.full       = (rc_q == RCW'(MAX_REGIONS));
		flags.oob        = oob_q;
		flags.small_rgn  = small_q;
		flags.hit        = |col;
		flags.top        = (o_q == OW'(NUM_ORDERS - 1));
		flags.lay_last   = (o_q == OW'(NUM_ORDERS - 1));
		flags.split_done = (o_q == order_q);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {rc_idx, o_q};
		ram_wdata = next_q;
		ram_re    = 1'b0;
		ram_raddr = {pick, o_q};
		case (cmd.op)
			OP_LAY: begin
				ram_we = len_q[PAGE_SHIFT];
			end
			OP_SEARCH: begin
				ram_re = |col;
			end
			OP_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = {r_q, o_dn};
				ram_wdata = addr_q + 64'(size_q >> 1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bba_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q    <= '0;
			valid_q <= '0;
		end else begin
			case (cmd.op)
				OP_LAY:    valid_q[rc_idx][o_q] <= len_q[PAGE_SHIFT];
				OP_SEARCH: if (|col) valid_q[pick][o_q] <= 1'b0;
				OP_SPLIT:  valid_q[r_q][o_dn] <= 1'b1;
				OP_EMIT: begin
					if (cmd.st == ST_OK && !is_alloc_q) rc_q <= rc_q + RCW'(1);
				end
				default: rc_q <= rc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				is_alloc_q <= req_type;
				oob_q      <= (32'(block_order) >= NUM_ORDERS);
				base_q     <= {2'b00, region_base};
				len_q      <= region_len;
				order_q    <= OW'(block_order);
				o_q        <= OW'(block_order);
			end
			OP_BMP: begin
				bmp_q <= dbl[38:3];
			end
			OP_TRIM: begin
				small_q <= ({12'd0, bmp_q} > len_q);
				base_q  <= base_q + 50'(bmp_q);
				len_q   <= len_q - 48'(bmp_q);
			end
			OP_ALIGN: begin
				small_q <= small_q | (48'(pad) > len_q);
				base_q  <= base_q + 50'(pad);
				len_q   <= len_q - 48'(pad);
			end
			OP_MAP: begin
				next_q <= 64'(base_q) + map_base;
				size_q <= 48'(PAGE_SIZE);
				o_q    <= '0;
			end
			OP_LAY: begin
				if (len_q[PAGE_SHIFT]) next_q <= next_q + 64'(size_q);
				size_q <= size_q << 1;
				len_q  <= len_q >> 1;
				o_q    <= o_q + OW'(1);
			end
			OP_SEARCH: begin
				if (|col) begin
					r_q <= pick;
				end else begin
					o_q <= o_q + OW'(1);
				end
			end
			OP_TAKE: begin
				addr_q <= ram_rdata;
				size_q <= 48'(PAGE_SIZE) << o_q;
			end
			OP_SPLIT: begin
				size_q <= size_q >> 1;
				o_q    <= o_dn;
			end
			OP_EMIT: begin
				status <= cmd.st;
				if (cmd.st == ST_OK && is_alloc_q) begin
					block_address <= addr_q;
					region_index  <= 3'(r_q);
				end else if (cmd.st == ST_OK) begin
					block_address <= '0;
					region_index  <= 3'(rc_q);
				end else begin
					block_address <= '0;
					region_index  <= '0;
				end
			end
			default: begin
				o_q <= o_q;
			end
		endcase
	end

endmodule

`default_nettype wire
